// ===== sv/mfe_pkg.sv =====
`timescale 1ns / 1ps

package mfe_pkg;

  // Motor count and derived widths
  localparam int MotorCount = 8;
  localparam int MotorIdxW  = (MotorCount > 1) ? $clog2(MotorCount) : 1;
  localparam int PulseW     = 11;
  localparam int RampLenW   = 20;
  localparam int TimeW      = 32;
  localparam int ProdW      = PulseW + RampLenW;
  localparam int HdrLen     = 5;
  localparam int FrameLen   = HdrLen + 2 * MotorCount + 1;
  localparam int CntW       = $clog2(FrameLen);

  // Frame constants
  localparam logic [7:0] Hdr0        = 8'd36;
  localparam logic [7:0] Hdr1        = 8'd77;
  localparam logic [7:0] Hdr2        = 8'd60;
  localparam logic [7:0] CmdSetMotor = 8'd214;
  localparam logic [7:0] SizeByte    = 8'(2 * MotorCount);
  localparam logic [7:0] ChkInit     = SizeByte ^ CmdSetMotor;

  // Register reset values
  localparam logic [RampLenW-1:0] RampLenReset   = 20'd200000;
  localparam logic [PulseW-1:0]   RampBaseReset  = 11'd1000;
  localparam logic [PulseW-1:0]   IdlePulseReset = 11'd1000;

  typedef logic [PulseW-1:0] pulse_t;
  typedef pulse_t [MotorCount-1:0] pulse_arr_t;

  typedef enum logic [1:0] {
    RegRampLen   = 2'd0,
    RegRampBase  = 2'd1,
    RegIdlePulse = 2'd2
  } mfe_reg_e;

  typedef struct packed {
    logic [RampLenW-1:0] ramp_len;
    pulse_t              ramp_base;
    pulse_t              idle_pulse;
  } mfe_cfg_t;

  // Finished pulse set handed to the frame transmitter
  typedef struct packed {
    logic       valid;
    pulse_arr_t pulses;
  } mfe_frame_req_t;

  // Divider result
  typedef struct packed {
    logic       done;
    pulse_t     quot;
    logic       rem_nz;
  } mfe_div_res_t;

  // Fixed header byte by position
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = Hdr0;
      3'd1:    b = Hdr1;
      3'd2:    b = Hdr2;
      3'd3:    b = SizeByte;
      3'd4:    b = CmdSetMotor;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/mfe_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller guarantees
// the quotient fits in PulseW bits.
module mfe_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mfe_pkg::ProdW-1:0]       dividend_i,
  input  logic [mfe_pkg::RampLenW-1:0]    divisor_i,
  output mfe_pkg::mfe_div_res_t           res_o
);

  localparam int StepW = $clog2(mfe_pkg::PulseW + 1);

  logic                          busy_q;
  logic                          done_q;
  logic [StepW-1:0]              step_q;
  logic [mfe_pkg::RampLenW-1:0]  rem_q;
  logic [mfe_pkg::RampLenW-1:0]  div_q;
  logic [mfe_pkg::PulseW-1:0]    quo_q;

  logic [mfe_pkg::RampLenW:0]    trial;
  logic [mfe_pkg::RampLenW:0]    trial_sub;
  logic                          fit;
  logic [mfe_pkg::RampLenW-1:0]  rem_d;

  // Shift in one dividend bit and try the subtract
  always_comb begin
    trial     = {rem_q, quo_q[mfe_pkg::PulseW-1]};
    fit       = trial >= {1'b0, div_q};
    trial_sub = trial - {1'b0, div_q};
    rem_d     = fit ? trial_sub[mfe_pkg::RampLenW-1:0] : trial[mfe_pkg::RampLenW-1:0];
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(mfe_pkg::PulseW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[mfe_pkg::ProdW-1:mfe_pkg::PulseW];
      quo_q <= dividend_i[mfe_pkg::PulseW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[mfe_pkg::PulseW-2:0], fit};
    end
  end

  assign res_o.done   = done_q;
  assign res_o.quot   = quo_q;
  assign res_o.rem_nz = |rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < div_q)
    else $error("divider remainder not below divisor");

endmodule

// ===== sv/mfe_pulse_calc.sv =====
`timescale 1ns / 1ps

// Works out the pulse for every motor: idle, ramp base, ramped or direct.
module mfe_pulse_calc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfe_pkg::mfe_cfg_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mfe_pkg::pulse_arr_t           speeds_i,
  input  logic [mfe_pkg::TimeW-1:0]     now_i,
  input  logic                          emerg_i,
  output mfe_pkg::mfe_frame_req_t       req_o,
  input  logic                          req_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL,
    S_DIV,
    S_WAIT,
    S_DONE
  } state_e;

  state_e                          state_q;
  logic [mfe_pkg::MotorIdxW-1:0]   idx_q;
  logic                            started_q;
  logic [mfe_pkg::TimeW-1:0]       start_time_q;

  mfe_pkg::pulse_arr_t             speed_q;
  logic [mfe_pkg::TimeW-1:0]       now_q;
  logic                            emerg_q;
  logic [mfe_pkg::RampLenW-1:0]    elapsed_q;
  logic [mfe_pkg::ProdW-1:0]       prod_q;
  logic                            neg_q;
  mfe_pkg::pulse_arr_t             pulse_q;

  logic [mfe_pkg::TimeW-1:0]       elapsed;
  logic                            in_ramp;
  logic [mfe_pkg::PulseW:0]        diff;
  logic [mfe_pkg::PulseW:0]        diff_abs;
  logic [mfe_pkg::PulseW-1:0]      mag;
  logic [mfe_pkg::PulseW:0]        down_step;
  logic [mfe_pkg::PulseW:0]        ramp_sum;
  logic                            last_motor;
  logic                            div_start;
  mfe_pkg::mfe_div_res_t           div_res;

  // Elapsed time and ramp window test
  always_comb begin
    elapsed = now_q - start_time_q;
    in_ramp = elapsed < {{(mfe_pkg::TimeW - mfe_pkg::RampLenW){1'b0}}, cfg_i.ramp_len};
  end

  // Signed distance from the ramp base for the current motor
  always_comb begin
    diff     = {1'b0, speed_q[idx_q]} - {1'b0, cfg_i.ramp_base};
    diff_abs = diff[mfe_pkg::PulseW] ? (~diff + 1'b1) : diff;
    mag      = diff_abs[mfe_pkg::PulseW-1:0];
  end

  // Apply the quotient; a falling ramp rounds toward minus infinity
  always_comb begin
    down_step = {1'b0, div_res.quot} + {{mfe_pkg::PulseW{1'b0}}, div_res.rem_nz};
    ramp_sum  = neg_q ? ({1'b0, cfg_i.ramp_base} - down_step)
                      : ({1'b0, cfg_i.ramp_base} + {1'b0, div_res.quot});
  end

  assign last_motor = idx_q == mfe_pkg::MotorIdxW'(mfe_pkg::MotorCount - 1);
  assign div_start  = state_q == S_DIV;
  assign in_ready_o = state_q == S_IDLE;

  mfe_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (cfg_i.ramp_len),
    .res_o      (div_res)
  );

  // Sequencer and ramp state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      started_q    <= 1'b0;
      start_time_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          idx_q <= '0;
          priority if (emerg_q) begin
            state_q <= S_DONE;
          end else if (!started_q) begin
            started_q    <= 1'b1;
            start_time_q <= now_q;
            state_q      <= S_DONE;
          end else if (!in_ramp) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (div_res.done) begin
            if (last_motor) begin
              state_q <= S_DONE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_MUL;
            end
          end
        end
        S_DONE: begin
          if (req_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item, product and pulse registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      speed_q <= speeds_i;
      now_q   <= now_i;
      emerg_q <= emerg_i;
    end
    if (state_q == S_DECIDE) begin
      elapsed_q <= elapsed[mfe_pkg::RampLenW-1:0];
      for (int j = 0; j < mfe_pkg::MotorCount; j++) begin
        priority if (emerg_q) begin
          pulse_q[j] <= cfg_i.idle_pulse;
        end else if (!started_q) begin
          pulse_q[j] <= cfg_i.ramp_base;
        end else begin
          pulse_q[j] <= speed_q[j];
        end
      end
    end
    if (state_q == S_MUL) begin
      neg_q  <= diff[mfe_pkg::PulseW];
      prod_q <= mfe_pkg::ProdW'(mag) * mfe_pkg::ProdW'(elapsed_q);
    end
    if (state_q == S_WAIT && div_res.done) begin
      pulse_q[idx_q] <= ramp_sum[mfe_pkg::PulseW-1:0];
    end
  end

  assign req_o.valid  = state_q == S_DONE;
  assign req_o.pulses = pulse_q;

endmodule

// ===== sv/mfe_frame_tx.sv =====
`timescale 1ns / 1ps

// Serializes one pulse set into a motor frame, one byte per transfer.
module mfe_frame_tx (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mfe_pkg::mfe_frame_req_t  req_i,
  output logic                     req_ready_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic [7:0]               m_data_o,
  output logic                     m_last_o
);

  logic                          busy_q;
  logic [mfe_pkg::CntW-1:0]      cnt_q;
  logic [7:0]                    chk_q;
  mfe_pkg::pulse_arr_t           buf_q;
  logic                          valid_q;
  logic [7:0]                    data_q;
  logic                          last_q;

  logic                          adv;
  logic                          load;
  logic                          is_hdr;
  logic                          is_chk;
  logic [mfe_pkg::CntW-1:0]      off;
  logic [mfe_pkg::MotorIdxW-1:0] motor;
  logic [7:0]                    pay_byte;
  logic [7:0]                    next_byte;

  assign load        = !busy_q && req_i.valid;
  assign adv         = busy_q && (!valid_q || m_ready_i);
  assign req_ready_o = !busy_q;

  // Pick the byte at the current frame position
  always_comb begin
    is_hdr   = cnt_q < mfe_pkg::CntW'(mfe_pkg::HdrLen);
    is_chk   = cnt_q == mfe_pkg::CntW'(mfe_pkg::FrameLen - 1);
    off      = cnt_q - mfe_pkg::CntW'(mfe_pkg::HdrLen);
    motor    = off[mfe_pkg::MotorIdxW:1];
    pay_byte = off[0] ? {{(16 - mfe_pkg::PulseW){1'b0}}, buf_q[motor][mfe_pkg::PulseW-1:8]}
                      : buf_q[motor][7:0];
    priority if (is_hdr) begin
      next_byte = mfe_pkg::hdr_byte(cnt_q[2:0]);
    end else if (is_chk) begin
      next_byte = chk_q;
    end else begin
      next_byte = pay_byte;
    end
  end

  // Frame position and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (adv) begin
        if (is_chk) begin
          busy_q <= 1'b0;
          cnt_q  <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (adv) begin
        valid_q <= 1'b1;
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Pulse buffer, checksum and output byte
  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= req_i.pulses;
      chk_q <= mfe_pkg::ChkInit;
    end else if (adv && !is_hdr && !is_chk) begin
      chk_q <= chk_q ^ pay_byte;
    end
    if (adv) begin
      data_q <= next_byte;
      last_q <= is_chk;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_last_o  = last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < mfe_pkg::CntW'(mfe_pkg::FrameLen))
    else $error("frame position out of range");

  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_chk |=> !busy_q && valid_q && last_q)
    else $error("checksum byte did not close the frame");

endmodule

// ===== sv/motor_frame_encoder_with_ramp.sv =====
`timescale 1ns / 1ps
// Emergency, first and post-ramp items are decided directly; in the ramp each motor
// also runs in turn through the shared multiply and the 11-step restoring divider.
// Frames are 22 bytes, one byte per output transfer. A new input item is taken once
// the previous pulse set has been handed to the frame transmitter, while that frame
// is still being sent.
// Reset: asynchronous active low; configuration registers return to defaults, ramp not started.
module motor_frame_encoder_with_ramp (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // motor_speed_0..7 (11 bits each, from bit 0), now_us [119:88]
  input  logic [119:0] s_axis_tdata_i,
  // emergency_stop
  input  logic         s_axis_tuser_i,
  // Output stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // frame_byte
  output logic [7:0]   m_axis_tdata_o,
  // frame_end
  output logic         m_axis_tlast_o
);

  localparam int NowLsb = 8 * mfe_pkg::PulseW;

  logic [mfe_pkg::RampLenW-1:0] ramp_len_q;
  mfe_pkg::pulse_t              ramp_base_q;
  mfe_pkg::pulse_t              idle_pulse_q;
  mfe_pkg::mfe_cfg_t            cfg;
  mfe_pkg::mfe_reg_e            reg_sel;
  logic                         cfg_wr;

  mfe_pkg::pulse_arr_t          speeds;
  logic [mfe_pkg::TimeW-1:0]    now_us;
  mfe_pkg::mfe_frame_req_t      req;
  logic                         req_ready;

  // Register decode
  assign pready  = 1'b1;
  assign reg_sel = mfe_pkg::mfe_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_len_q   <= mfe_pkg::RampLenReset;
      ramp_base_q  <= mfe_pkg::RampBaseReset;
      idle_pulse_q <= mfe_pkg::IdlePulseReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        mfe_pkg::RegRampLen:   ramp_len_q   <= pwdata[mfe_pkg::RampLenW-1:0];
        mfe_pkg::RegRampBase:  ramp_base_q  <= pwdata[mfe_pkg::PulseW-1:0];
        mfe_pkg::RegIdlePulse: idle_pulse_q <= pwdata[mfe_pkg::PulseW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      mfe_pkg::RegRampLen:   prdata = {{(32 - mfe_pkg::RampLenW){1'b0}}, ramp_len_q};
      mfe_pkg::RegRampBase:  prdata = {{(32 - mfe_pkg::PulseW){1'b0}}, ramp_base_q};
      mfe_pkg::RegIdlePulse: prdata = {{(32 - mfe_pkg::PulseW){1'b0}}, idle_pulse_q};
      default:               prdata = '0;
    endcase
  end

  assign cfg.ramp_len   = ramp_len_q;
  assign cfg.ramp_base  = ramp_base_q;
  assign cfg.idle_pulse = idle_pulse_q;

  // Unpack the input transfer
  always_comb begin
    for (int j = 0; j < mfe_pkg::MotorCount; j++) begin
      speeds[j] = s_axis_tdata_i[j*mfe_pkg::PulseW +: mfe_pkg::PulseW];
    end
    now_us = s_axis_tdata_i[NowLsb +: mfe_pkg::TimeW];
  end

  mfe_pulse_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .speeds_i    (speeds),
    .now_i       (now_us),
    .emerg_i     (s_axis_tuser_i),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  mfe_frame_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_ready_o (req_ready),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o),
    .m_last_o    (m_axis_tlast_o)
  );

endmodule

// ===== tb/sv/mfe_frame_checker.sv =====
`timescale 1ns / 1ps

module mfe_frame_checker
  import mfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB side, observed only
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic         pready_i,
  input  logic [3:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  // Command stream into the encoder
  input  logic         cmd_tvalid_i,
  input  logic         cmd_tready_i,
  // motor_speed_0..7 (11 bits each, from bit 0), now_us [119:88]
  input  logic [119:0] cmd_tdata_i,
  // emergency_stop
  input  logic         cmd_tuser_i,
  // Frame byte stream out of the encoder
  input  logic         frm_tvalid_i,
  input  logic         frm_tready_i,
  // frame_byte
  input  logic [7:0]   frm_tdata_i,
  // frame_end
  input  logic         frm_tlast_i,
  output int           err_count_o,
  output int           pending_o
);

  localparam int TimeLsb = MotorCount * PulseW;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         pos;
  } frame_byte_t;

  frame_byte_t frame_q[$];

  // Shadow of the register file and the soft-start state
  logic [RampLenW-1:0] ramp_len_q;
  pulse_t              ramp_base_q;
  pulse_t              idle_pulse_q;
  logic                ramp_on_q;
  logic [TimeW-1:0]    ramp_t0_q;

  task automatic report_mismatch(input string msg);
    err_count_o++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Interpolate between the ramp base and the target, rounding toward minus infinity
  function automatic pulse_t ramp_pulse(input pulse_t target, input logic [TimeW-1:0] elapsed);
    longint base;
    longint tgt;
    longint diff;
    longint len;
    longint e;
    longint step;
    base = ramp_base_q;
    tgt  = target;
    len  = ramp_len_q;
    e    = elapsed;
    diff = tgt - base;
    if (diff >= 0) step = (diff * e) / len;
    else step = -(((-diff) * e + len - 1) / len);
    return pulse_t'(base + step);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last, inout int pos);
    frame_byte_t fb;
    fb.data = b;
    fb.last = last;
    fb.pos  = pos;
    frame_q = {frame_q, fb};
    pos++;
  endtask

  // Work out the pulse set for one command and queue the bytes of its frame
  task automatic predict_frame(input logic [119:0] data, input logic estop);
    pulse_t           pulses [MotorCount];
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] elapsed;
    logic [7:0]       chk;
    logic [7:0]       lo;
    logic [7:0]       hi;
    pulse_t           target;
    int               pos;
    now = data[TimeLsb +: TimeW];
    pos = 0;
    if (estop) begin
      for (int j = 0; j < MotorCount; j++) pulses[j] = idle_pulse_q;
    end else if (!ramp_on_q) begin
      ramp_on_q = 1'b1;
      ramp_t0_q = now;
      for (int j = 0; j < MotorCount; j++) pulses[j] = ramp_base_q;
    end else begin
      elapsed = now - ramp_t0_q;
      for (int j = 0; j < MotorCount; j++) begin
        target = data[j*PulseW +: PulseW];
        pulses[j] = (elapsed < {12'd0, ramp_len_q}) ? ramp_pulse(target, elapsed) : target;
      end
    end
    push_byte(Hdr0, 1'b0, pos);
    push_byte(Hdr1, 1'b0, pos);
    push_byte(Hdr2, 1'b0, pos);
    push_byte(SizeByte, 1'b0, pos);
    push_byte(CmdSetMotor, 1'b0, pos);
    chk = SizeByte ^ CmdSetMotor;
    for (int j = 0; j < MotorCount; j++) begin
      lo = pulses[j][7:0];
      hi = 8'(pulses[j] >> 8);
      push_byte(lo, 1'b0, pos);
      push_byte(hi, 1'b0, pos);
      chk = chk ^ lo ^ hi;
    end
    push_byte(chk, 1'b1, pos);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_byte_t exp_b;
    if (!rst_ni) begin
      ramp_len_q   = RampLenReset;
      ramp_base_q  = RampBaseReset;
      idle_pulse_q = IdlePulseReset;
      ramp_on_q    = 1'b0;
      ramp_t0_q    = '0;
      frame_q.delete();
      pending_o    = 0;
    end else begin
      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (mfe_reg_e'(paddr_i[3:2]))
          RegRampLen:   ramp_len_q   = pwdata_i[RampLenW-1:0];
          RegRampBase:  ramp_base_q  = pwdata_i[PulseW-1:0];
          RegIdlePulse: idle_pulse_q = pwdata_i[PulseW-1:0];
          default: ;
        endcase
      end
      // Predict on every command transfer
      if (cmd_tvalid_i && cmd_tready_i) predict_frame(cmd_tdata_i, cmd_tuser_i);
      // Compare every frame byte transfer with the oldest expectation
      if (frm_tvalid_i && frm_tready_i) begin
        if (frame_q.size() == 0) begin
          report_mismatch($sformatf("byte %0h with no frame pending", frm_tdata_i));
        end else begin
          exp_b = frame_q.pop_front();
          if (frm_tdata_i !== exp_b.data)
            report_mismatch($sformatf("frame byte %0d: got %0d, want %0d",
                                      exp_b.pos, frm_tdata_i, exp_b.data));
          if (frm_tlast_i !== exp_b.last)
            report_mismatch($sformatf("frame byte %0d: tlast got %0b, want %0b",
                                      exp_b.pos, frm_tlast_i, exp_b.last));
        end
      end
      pending_o = frame_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_motor_frame_encoder_with_ramp.sv =====
`timescale 1ns / 1ps

module tb_motor_frame_encoder_with_ramp;
  import mfe_pkg::*;

  typedef struct packed {
    logic [TimeW-1:0] now;
    pulse_arr_t       speed;
    logic             estop;
  } motor_cmd_t;

  logic         clk_i;
  logic         rst_ni;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         cmd_tvalid;
  logic         cmd_tready;
  logic [119:0] cmd_tdata;
  logic         cmd_tuser;
  logic         frm_tvalid;
  logic         frm_tready;
  logic [7:0]   frm_tdata;
  logic         frm_tlast;
  int           err_count;
  int           pending_bytes;

  // Stimulus-side view of config and ramp start, used only to aim timestamps and speeds
  int unsigned      cfg_len;
  int unsigned      cfg_base;
  bit               ramp_on;
  logic [TimeW-1:0] ramp_t0;
  int               burst_left;
  bit               no_gaps;
  bit               hold_off_req;

  motor_frame_encoder_with_ramp DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (cmd_tvalid),
    .s_axis_tready_o (cmd_tready),
    .s_axis_tdata_i  (cmd_tdata),
    .s_axis_tuser_i  (cmd_tuser),
    .m_axis_tvalid_o (frm_tvalid),
    .m_axis_tready_i (frm_tready),
    .m_axis_tdata_o  (frm_tdata),
    .m_axis_tlast_o  (frm_tlast)
  );

  mfe_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .cmd_tvalid_i (cmd_tvalid),
    .cmd_tready_i (cmd_tready),
    .cmd_tdata_i  (cmd_tdata),
    .cmd_tuser_i  (cmd_tuser),
    .frm_tvalid_i (frm_tvalid),
    .frm_tready_i (frm_tready),
    .frm_tdata_i  (frm_tdata),
    .frm_tlast_i  (frm_tlast),
    .err_count_o  (err_count),
    .pending_o    (pending_bytes)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Frame receiver: ready pattern changes by segment, with one long hold-off on request
  initial begin : receiver
    int seg_left;
    int mode;
    seg_left = 0;
    mode     = 0;
    frm_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        frm_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(20, 120);
        end
        seg_left--;
        case (mode)
          0:       frm_tready <= 1'b1;
          1:       frm_tready <= ($urandom_range(0, 99) < 70);
          default: frm_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic cfg_write(input mfe_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int unsigned len, input int unsigned base,
                            input int unsigned idle);
    cfg_write(RegRampLen, len);
    cfg_write(RegRampBase, base);
    cfg_write(RegIdlePulse, idle);
    cfg_len  = len;
    cfg_base = base;
  endtask

  // Offer one command, with a random gap at the end of each burst
  task automatic send_cmd(input motor_cmd_t c);
    if (burst_left <= 0) begin
      cmd_tvalid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 40)) @(posedge clk_i);
      else repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = no_gaps ? 1000 : $urandom_range(1, 10);
    end
    cmd_tvalid <= 1'b1;
    cmd_tdata  <= {c.now, c.speed};
    cmd_tuser  <= c.estop;
    do @(posedge clk_i); while (!cmd_tready);
    burst_left--;
    if (!c.estop && !ramp_on) begin
      ramp_on = 1'b1;
      ramp_t0 = c.now;
    end
  endtask

  // Stop offering and wait until every frame byte has come out
  task automatic drain(input int settle);
    cmd_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic motor_cmd_t cmd_fill(input pulse_t v, input logic [TimeW-1:0] now,
                                          input logic estop);
    motor_cmd_t c;
    for (int j = 0; j < MotorCount; j++) c.speed[j] = v;
    c.now   = now;
    c.estop = estop;
    return c;
  endfunction

  function automatic pulse_t rand_speed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return pulse_t'(cfg_base + $urandom_range(0, 8) - 4);
      default: return pulse_t'($urandom);
    endcase
  endfunction

  // Aim most timestamps inside the ramp window, some past it, some before the start
  function automatic logic [TimeW-1:0] rand_now();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (!ramp_on || sel < 15) return $urandom;
    if (sel < 70 && cfg_len != 0) return ramp_t0 + $urandom_range(0, cfg_len - 1);
    if (sel < 90) return ramp_t0 + cfg_len + $urandom_range(0, 5000);
    return ramp_t0 - $urandom_range(1, 1000);
  endfunction

  function automatic motor_cmd_t rand_cmd();
    motor_cmd_t c;
    for (int j = 0; j < MotorCount; j++) c.speed[j] = rand_speed();
    c.now   = rand_now();
    c.estop = ($urandom_range(0, 9) == 0);
    return c;
  endfunction

  initial begin : stimulus
    motor_cmd_t c;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cmd_tvalid   <= 1'b0;
    cmd_tdata    <= '0;
    cmd_tuser    <= 1'b0;
    hold_off_req = 1'b0;
    cfg_len      = RampLenReset;
    cfg_base     = RampBaseReset;
    ramp_on      = 1'b0;
    ramp_t0      = '0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: emergency before the ramp starts, then the ramp start itself
    c = rand_cmd();
    c.now   = '0;
    c.estop = 1'b1;
    send_cmd(c);
    send_cmd(cmd_fill('1, '1, 1'b1));
    send_cmd(cmd_fill('1, 32'd1000, 1'b0));
    send_cmd(cmd_fill('0, 32'd1000, 1'b0));
    c = cmd_fill('0, 32'd1000 + 32'd199999, 1'b0);
    for (int j = 1; j < MotorCount; j += 2) c.speed[j] = '1;
    send_cmd(c);
    send_cmd(cmd_fill('1, 32'd1000 + 32'd200000, 1'b0));
    c = rand_cmd();
    c.now   = 32'd1000 + 32'd100000;
    c.estop = 1'b0;
    send_cmd(c);
    // Timestamp before the start wraps to a huge elapsed time
    c = rand_cmd();
    c.now   = 32'd999;
    c.estop = 1'b0;
    send_cmd(c);
    send_cmd(cmd_fill('0, '1, 1'b0));
    c = cmd_fill(11'h555, '0, 1'b0);
    for (int j = 1; j < MotorCount; j += 2) c.speed[j] = 11'h2AA;
    send_cmd(c);
    send_cmd(cmd_fill('1, 32'd5000, 1'b1));

    // Shortest ramp, zero base and idle
    drain(8);
    set_config(1, 0, 0);
    send_cmd(cmd_fill('1, ramp_t0, 1'b0));
    send_cmd(cmd_fill('1, ramp_t0 + 1, 1'b0));
    send_cmd(cmd_fill('1, ramp_t0, 1'b1));

    // Zero ramp length passes commands straight through
    drain(8);
    set_config(0, 2047, 2047);
    send_cmd(cmd_fill('0, ramp_t0, 1'b0));
    send_cmd(cmd_fill('0, ramp_t0, 1'b1));

    // Longest ramp falling from the top base
    drain(8);
    set_config(1000000, 2047, 1000);
    send_cmd(cmd_fill('0, ramp_t0 + 333333, 1'b0));
    c = rand_cmd();
    c.now   = ramp_t0 + 999999;
    c.estop = 1'b0;
    send_cmd(c);
    send_cmd(cmd_fill('1, ramp_t0 + 1, 1'b0));

    // Random phases, each with its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      drain(8);
      case ($urandom_range(0, 3))
        0:       cfg_len = $urandom_range(1, 64);
        1:       cfg_len = $urandom_range(1, 1000000);
        2:       cfg_len = 1000000;
        default: cfg_len = $urandom_range(1000, 300000);
      endcase
      set_config(cfg_len, $urandom_range(0, 2047), $urandom_range(0, 2047));
      no_gaps = ($urandom_range(0, 3) == 0);
      // Hold the receiver off while commands keep coming, to back up the encoder
      if (phase == 2) begin
        no_gaps      = 1'b1;
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < 45; n++) send_cmd(rand_cmd());
    end

    drain(20);
    if (err_count == 0 && pending_bytes == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
